@@ design/msov_pkg.sv @@
// Package for the mode stack: widths, operation codes and error codes.
package msov_pkg;

	localparam int MODE_WIDTH  = 32;
	localparam int STACK_DEPTH = 16;
	localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int OP_W        = 3;
	localparam int ERR_W       = 3;

	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_POP     = 3'd1;
	localparam logic [OP_W-1:0] OP_SET     = 3'd2;
	localparam logic [OP_W-1:0] OP_ENABLE  = 3'd3;
	localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

	localparam logic [ERR_W-1:0] ERR_OK            = 3'd0;
	localparam logic [ERR_W-1:0] ERR_POP_CHECK     = 3'd1;
	localparam logic [ERR_W-1:0] ERR_POP_EMPTY     = 3'd2;
	localparam logic [ERR_W-1:0] ERR_ALREADY_ON    = 3'd3;
	localparam logic [ERR_W-1:0] ERR_DISABLE_CHECK = 3'd4;
	localparam logic [ERR_W-1:0] ERR_STACK_FULL    = 3'd5;

	typedef logic [MODE_WIDTH-1:0] mode_t;
	typedef logic [LEVEL_W-1:0]    level_t;

endpackage

@@ design/msov_req_if.sv @@
// Request channel: operation code and mode operand word.
interface msov_req_if;
	logic                        valid;
	logic                        ready;
	logic [msov_pkg::OP_W-1:0]   req_type;
	msov_pkg::mode_t             mode_bits;

	modport source (output valid, output req_type, output mode_bits, input ready);
	modport sink   (input valid, input req_type, input mode_bits, output ready);
endinterface

@@ design/msov_rsp_if.sv @@
// Response channel: mode, overlay, stack level and error code word.
interface msov_rsp_if;
	logic                        valid;
	logic                        ready;
	msov_pkg::mode_t             current_mode;
	msov_pkg::mode_t             overlay_bits;
	msov_pkg::level_t            stack_level;
	logic [msov_pkg::ERR_W-1:0]  error_code;

	modport source (output valid, output current_mode, output overlay_bits,
		output stack_level, output error_code, input ready);
	modport sink   (input valid, input current_mode, input overlay_bits,
		input stack_level, input error_code, output ready);
endinterface

@@ design/mode_stack_with_overlay.sv @@
// Mode stack with overlay: mode word, overlay mask and bounded save stack.
//
//  channel | dir | payload                                          | handshake
//  req     | in  | req_type, mode_bits                              | valid/ready
//  rsp     | out | current_mode, overlay_bits, stack_level, error_code | valid/ready
//
// One word per cycle sustained while rsp is ready; a request passes the input register,
// then the state and result registers, updated together, before it shows on rsp.
// The response fields are the state registers themselves, so they hold while rsp stalls.
// req stays ready while the input register is empty or can move on this cycle.
// Reset clears mode, overlay, level and the valid flags; stack entries are left as is.
module mode_stack_with_overlay (
	input logic          clk,
	input logic          arst_n,
	msov_req_if.sink     req,
	msov_rsp_if.source   rsp
);

	logic                             valid_s1;
	logic [msov_pkg::OP_W-1:0]        op_s1;
	msov_pkg::mode_t                  bits_s1;

	msov_pkg::mode_t                  mode_q;
	msov_pkg::mode_t                  overlay_q;
	msov_pkg::level_t                 level_q;
	logic [msov_pkg::ERR_W-1:0]       err_q;
	logic                             out_valid_q;
	msov_pkg::mode_t                  stack_q [msov_pkg::STACK_DEPTH];

	logic                             advance;
	msov_pkg::mode_t                  mode_d;
	msov_pkg::mode_t                  overlay_d;
	msov_pkg::level_t                 level_d;
	logic [msov_pkg::ERR_W-1:0]       err_d;
	logic                             push_en;
	msov_pkg::mode_t                  top_entry;
	msov_pkg::level_t                 top_idx;
	msov_pkg::mode_t                  add_bits;
	msov_pkg::mode_t                  rem_bits;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.req_type;
			bits_s1 <= req.mode_bits;
		end
	end

	assign top_idx   = level_q - msov_pkg::level_t'(1);
	assign top_entry = stack_q[top_idx[msov_pkg::PTR_W-1:0]];
	assign add_bits  = bits_s1 & ~mode_q;
	assign rem_bits  = overlay_q & bits_s1;

	always_comb begin
		mode_d    = mode_q;
		overlay_d = overlay_q;
		level_d   = level_q;
		err_d     = msov_pkg::ERR_OK;
		push_en   = 1'b0;
		case (op_s1)
			msov_pkg::OP_PUSH: begin
				if (level_q >= msov_pkg::level_t'(msov_pkg::STACK_DEPTH)) begin
					err_d = msov_pkg::ERR_STACK_FULL;
				end else begin
					push_en = 1'b1;
					level_d = level_q + msov_pkg::level_t'(1);
					mode_d  = mode_q | bits_s1;
				end
			end
			msov_pkg::OP_POP: begin
				if ((mode_q & bits_s1) != bits_s1) begin
					err_d = msov_pkg::ERR_POP_CHECK;
				end else if (level_q == '0) begin
					err_d = msov_pkg::ERR_POP_EMPTY;
				end else begin
					level_d = top_idx;
					mode_d  = top_entry | overlay_q;
				end
			end
			msov_pkg::OP_SET: begin
				overlay_d = '0;
				mode_d    = bits_s1;
			end
			msov_pkg::OP_ENABLE: begin
				if ((overlay_q & bits_s1) == bits_s1) begin
					err_d = msov_pkg::ERR_ALREADY_ON;
				end else begin
					overlay_d = overlay_q | add_bits;
					mode_d    = mode_q | add_bits;
				end
			end
			msov_pkg::OP_DISABLE: begin
				if ((mode_q & bits_s1) != bits_s1) begin
					err_d = msov_pkg::ERR_DISABLE_CHECK;
				end else begin
					overlay_d = overlay_q & ~rem_bits;
					mode_d    = mode_q & ~rem_bits;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			overlay_q   <= '0;
			level_q     <= '0;
			err_q       <= msov_pkg::ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q      <= mode_d;
				overlay_q   <= overlay_d;
				level_q     <= level_d;
				err_q       <= err_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push_en) begin
			stack_q[level_q[msov_pkg::PTR_W-1:0]] <= mode_q & ~overlay_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.current_mode = mode_q;
	assign rsp.overlay_bits = overlay_q;
	assign rsp.stack_level  = level_q;
	assign rsp.error_code   = err_q;

endmodule

@@ design/msov_checker.sv @@
// Port-level checks for the mode stack, bound to the top level.
module msov_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input msov_pkg::mode_t              rsp_mode,
	input msov_pkg::mode_t              rsp_overlay,
	input msov_pkg::level_t             rsp_level,
	input logic [msov_pkg::ERR_W-1:0]   rsp_err
);

	msov_pkg::mode_t   last_mode_q;
	msov_pkg::mode_t   last_overlay_q;
	msov_pkg::level_t  last_level_q;
	logic              rsp_fire;

	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mode_q    <= '0;
			last_overlay_q <= '0;
			last_level_q   <= '0;
		end else if (rsp_fire) begin
			last_mode_q    <= rsp_mode;
			last_overlay_q <= rsp_overlay;
			last_level_q   <= rsp_level;
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_level <= msov_pkg::level_t'(msov_pkg::STACK_DEPTH))
		else $error("stack level beyond depth");

	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire |-> (rsp_level == last_level_q) ||
			(rsp_level == last_level_q + msov_pkg::level_t'(1)) ||
			(rsp_level == last_level_q - msov_pkg::level_t'(1)))
		else $error("stack level moved by more than one");

	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire && (rsp_err != msov_pkg::ERR_OK) |->
			(rsp_mode == last_mode_q) && (rsp_overlay == last_overlay_q) &&
			(rsp_level == last_level_q))
		else $error("failed request changed state");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode) &&
			$stable(rsp_overlay) && $stable(rsp_level) && $stable(rsp_err))
		else $error("stalled response word changed");

endmodule

bind mode_stack_with_overlay msov_checker u_msov_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_mode    (rsp.current_mode),
	.rsp_overlay (rsp.overlay_bits),
	.rsp_level   (rsp.stack_level),
	.rsp_err     (rsp.error_code)
);
